// ----- src/rcfd_pkg.sv -----
// ============================================================================
// rcfd_pkg: shared types, constants and decode functions
// Frame layout constants, configuration register codes and the per-channel
// stick and mouse conversion used by the remote-control frame decoder.
// ============================================================================
`default_nettype none

package rcfd_pkg;

    localparam int unsigned STORE_DEPTH = 16;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned FRAME_BYTES = 18;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [COUNT_W-1:0] FRAME_COUNT = COUNT_W'(FRAME_BYTES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_LIMIT  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [10:0] RST_STICK_CENTER = 11'd1024;
    localparam logic [10:0] RST_STICK_LIMIT  = 11'd665;
    localparam logic [9:0]  RST_DEADBAND     = 10'd10;
    localparam logic [14:0] RST_MOUSE_LIMIT  = 15'd60;

    typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

    typedef struct packed {
        logic [10:0] stick_center;
        logic [10:0] stick_limit;
        logic [9:0]  deadband;
        logic [14:0] mouse_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic               snap_valid;
        logic [COUNT_W-1:0] byte_count;
    } cap_status_t;

    // Center a raw stick channel, zero it out of range, optionally deadband,
    // then saturate to the 11-bit signed output range.
    function automatic logic signed [10:0] stick_value(
        input logic [10:0] raw,
        input logic [10:0] center,
        input logic [10:0] limit,
        input logic [9:0]  dband,
        input logic        use_db
    );
        logic signed [12:0] v;
        logic signed [12:0] lim;
        logic signed [12:0] db;
        v   = $signed({2'b00, raw}) - $signed({2'b00, center});
        lim = $signed({2'b00, limit});
        db  = $signed({3'b000, dband});
        if (v >= lim || v <= -lim)
            v = '0;
        if (use_db && v <= db && v >= -db)
            v = '0;
        if (v > 13'sd1023)
            v = 13'sd1023;
        if (v < -13'sd1024)
            v = -13'sd1024;
        return $signed(v[10:0]);
    endfunction

    // Symmetric clamp of a little-endian two's complement mouse value.
    function automatic logic signed [15:0] mouse_clamp(
        input logic [7:0]  lo,
        input logic [7:0]  hi,
        input logic [14:0] limit
    );
        logic signed [16:0] v;
        logic signed [16:0] lim;
        v   = $signed({hi[7], hi, lo});
        lim = $signed({2'b00, limit});
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        return $signed(v[15:0]);
    endfunction

endpackage

`default_nettype wire

// ----- src/rcfd_in_if.sv -----
// ============================================================================
// rcfd_in_if: serial byte channel
// Carries one received byte or one line-idle event per item.
// ============================================================================
`default_nettype none

interface rcfd_in_if;
    logic       valid;
    logic       ready;
    logic       is_idle;
    logic [7:0] data_byte;

    modport source (output valid, output is_idle, output data_byte, input ready);
    modport sink   (input valid, input is_idle, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- src/rcfd_out_if.sv -----
// ============================================================================
// rcfd_out_if: decoded frame channel
// Carries one decoded remote-control frame per item.
// ============================================================================
`default_nettype none

interface rcfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] right_x;
    logic signed [10:0] right_y;
    logic signed [10:0] left_x;
    logic signed [10:0] left_y;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [16:0] mouse_x_twice_avg;
    logic signed [16:0] mouse_y_twice_avg;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;

    modport source (
        output valid, input ready,
        output right_x, output right_y, output left_x, output left_y,
        output switch_left, output switch_right,
        output mouse_x_twice_avg, output mouse_y_twice_avg, output mouse_z,
        output mouse_buttons, output key_bits
    );
    modport sink (
        input valid, output ready,
        input right_x, input right_y, input left_x, input left_y,
        input switch_left, input switch_right,
        input mouse_x_twice_avg, input mouse_y_twice_avg, input mouse_z,
        input mouse_buttons, input key_bits
    );
endinterface

`default_nettype wire

// ----- src/rcfd_cfg_if.sv -----
// ============================================================================
// rcfd_cfg_if: configuration write channel
// Carries a register index and write data per write.
// ============================================================================
`default_nettype none

interface rcfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rcfd_capture.sv -----
// ============================================================================
// rcfd_capture: byte counter, frame store and frame snapshot
// Counts bytes per frame, keeps the first sixteen, and on a good idle copies
// the store into a snapshot register for the decode stage.
// ============================================================================
`default_nettype none

module rcfd_capture (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rcfd_in_if.sink                   byte_in,
    input  wire logic                 advance,
    output rcfd_pkg::frame_t          frame,
    output rcfd_pkg::cap_status_t     status
);
    import rcfd_pkg::*;

    logic [7:0]         store_reg [STORE_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               snap_valid_reg;
    logic               snap_valid_next;
    frame_t             snap_reg;
    logic               accept;
    logic               hit;
    frame_t             store_flat;

    assign byte_in.ready = !snap_valid_reg || advance;
    assign accept        = byte_in.valid && byte_in.ready;
    assign hit           = accept && byte_in.is_idle && (count_reg == FRAME_COUNT);

    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_flat[i] = store_reg[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (byte_in.is_idle)
                count_next = '0;
            else if (count_reg != COUNT_MAX)
                count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (hit)
            snap_valid_next = 1'b1;
        else if (advance)
            snap_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Store only the first sixteen bytes of a frame
    always_ff @(posedge clk)
    begin
        if (accept && !byte_in.is_idle && !count_reg[COUNT_W-1])
            store_reg[count_reg[COUNT_W-2:0]] <= byte_in.data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (hit)
            snap_reg <= store_flat;
    end

    assign frame             = snap_reg;
    assign status.snap_valid = snap_valid_reg;
    assign status.byte_count = count_reg;

endmodule

`default_nettype wire

// ----- src/rcfd_decode.sv -----
// ============================================================================
// rcfd_decode: frame field decode and result register
// Unpacks sticks, switches, mouse and keys from a snapshot and holds the
// result until taken; keeps the previous clamped mouse x and y.
// ============================================================================
`default_nettype none

module rcfd_decode (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rcfd_pkg::cfg_regs_t    cfg_regs,
    input  wire rcfd_pkg::frame_t       frame,
    input  wire logic                   snap_valid,
    output logic                        advance,
    rcfd_out_if.source                  frame_out
);
    import rcfd_pkg::*;

    logic               out_valid_reg;
    logic               load;
    logic [10:0]        raw_rx;
    logic [10:0]        raw_ry;
    logic [10:0]        raw_lx;
    logic [10:0]        raw_ly;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] prev_mx_reg;
    logic signed [15:0] prev_my_reg;

    assign advance = !out_valid_reg || frame_out.ready;
    assign load    = snap_valid && advance;

    assign raw_rx = {frame[1][2:0], frame[0]};
    assign raw_ry = {frame[2][5:0], frame[1][7:3]};
    assign raw_lx = {frame[4][0], frame[3], frame[2][7:6]};
    assign raw_ly = {frame[5][3:0], frame[4][7:1]};

    assign mx = mouse_clamp(frame[6], frame[7], cfg_regs.mouse_limit);
    assign my = mouse_clamp(frame[8], frame[9], cfg_regs.mouse_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_mx_reg   <= '0;
            prev_my_reg   <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= snap_valid;
            if (load)
            begin
                prev_mx_reg <= mx;
                prev_my_reg <= my;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_out.right_x <= stick_value(raw_rx, cfg_regs.stick_center,
                                             cfg_regs.stick_limit, cfg_regs.deadband, 1'b1);
            frame_out.right_y <= stick_value(raw_ry, cfg_regs.stick_center,
                                             cfg_regs.stick_limit, cfg_regs.deadband, 1'b1);
            frame_out.left_x  <= stick_value(raw_lx, cfg_regs.stick_center,
                                             cfg_regs.stick_limit, cfg_regs.deadband, 1'b0);
            frame_out.left_y  <= stick_value(raw_ly, cfg_regs.stick_center,
                                             cfg_regs.stick_limit, cfg_regs.deadband, 1'b0);
            frame_out.switch_left       <= frame[5][7:6];
            frame_out.switch_right      <= frame[5][5:4];
            frame_out.mouse_x_twice_avg <= {mx[15], mx} + {prev_mx_reg[15], prev_mx_reg};
            frame_out.mouse_y_twice_avg <= {my[15], my} + {prev_my_reg[15], prev_my_reg};
            frame_out.mouse_z           <= $signed({frame[11], frame[10]});
            frame_out.mouse_buttons     <= {frame[13], frame[12]};
            frame_out.key_bits          <= {frame[15], frame[14]};
        end
    end

    assign frame_out.valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/rc_frame_decoder_top.sv -----
// ============================================================================
// rc_frame_decoder_top: remote-control frame decoder
// Assembles serial bytes into frames and decodes good frames into stick,
// switch, mouse and keyboard fields.
// ============================================================================
// Usage:
//   byte_in    - one item per received byte (is_idle = 0) or per line-idle
//                gap (is_idle = 1). An idle closes the frame; the frame is
//                decoded only when exactly FRAME_BYTES bytes came before it.
//   frame_out  - one item per good frame. Frames of any other length are
//                dropped without a trace; the mouse history is kept.
//   cfg        - register writes (stick center, stick limit, deadband, mouse
//                limit), always ready; write only while the block is quiet.
// Timing: one item per cycle on byte_in while byte_in.ready is high. A good
//   idle's frame passes first into the frame snapshot register, then through
//   the decode logic into the result register.
// Stall: a waiting result holds while frame_out.ready is low; byte_in keeps
//   accepting until a second good frame queues in the snapshot register,
//   which takes at least FRAME_BYTES + 1 items.
// Reset: the byte count, mouse history and both valid flags clear; the
//   configuration registers return to their defaults. The frame store has
//   no reset, since a decoded frame always overwrites every byte read.
// ============================================================================
`default_nettype none

module rc_frame_decoder_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rcfd_in_if.sink    byte_in,
    rcfd_out_if.source frame_out,
    rcfd_cfg_if.sink   cfg
);
    import rcfd_pkg::*;

    cfg_regs_t   cfg_reg;
    frame_t      frame;
    cap_status_t cap_status;
    logic        advance;
    logic        cfg_write;

    // Configuration registers: writes always land
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_center <= RST_STICK_CENTER;
            cfg_reg.stick_limit  <= RST_STICK_LIMIT;
            cfg_reg.deadband     <= RST_DEADBAND;
            cfg_reg.mouse_limit  <= RST_MOUSE_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                CFG_STICK_CENTER: cfg_reg.stick_center <= cfg.data[10:0];
                CFG_STICK_LIMIT:  cfg_reg.stick_limit  <= cfg.data[10:0];
                CFG_DEADBAND:     cfg_reg.deadband     <= cfg.data[9:0];
                CFG_MOUSE_LIMIT:  cfg_reg.mouse_limit  <= cfg.data;
                default:          cfg_reg.deadband     <= cfg_reg.deadband;
            endcase
        end
    end

    // Count and store bytes; snapshot a good frame
    rcfd_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .advance (advance),
        .frame   (frame),
        .status  (cap_status)
    );

    // Decode the snapshot into the result register
    rcfd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_reg),
        .frame      (frame),
        .snap_valid (cap_status.snap_valid),
        .advance    (advance),
        .frame_out  (frame_out)
    );

    // A snapshot that moves on must show up as a result
    a_snap_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cap_status.snap_valid && advance |=> frame_out.valid)
        else $error("snapshot advanced without a result");

    // Input stalls only when both stages hold a frame and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> cap_status.snap_valid && frame_out.valid && !frame_out.ready)
        else $error("input stalled without a full pipeline");

    // An accepted idle always restarts the byte count
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_in.valid && byte_in.ready && byte_in.is_idle |=> cap_status.byte_count == '0)
        else $error("byte count not cleared by idle");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: self-checking bench for the remote-control frame decoder
// Feeds serial bytes and line-idle events. A cycle-free model of the decoder
// runs next to it and predicts every decoded frame. Each frame leaving the
// block is compared field by field with the oldest prediction. A short table
// of hand-built frames comes first. Random frames follow under several
// register settings and several mixes of source gaps and sink stalls.
// ============================================================================
`default_nettype none

module tb_top;

    import rcfd_pkg::*;

    // One decoded frame, laid out like the output channel
    typedef struct packed {
        logic signed [10:0] right_x;
        logic signed [10:0] right_y;
        logic signed [10:0] left_x;
        logic signed [10:0] left_y;
        logic [1:0]         switch_left;
        logic [1:0]         switch_right;
        logic signed [16:0] mouse_x_twice_avg;
        logic signed [16:0] mouse_y_twice_avg;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
    } frame_result_t;

    // One row of the directed table: a frame of nbytes bytes (the first 16
    // from content, the rest filler) closed by an idle. When has_want is
    // set, the typed-in result replaces the model's prediction.
    typedef struct {
        int            nbytes;
        frame_t        content;
        bit            has_want;
        frame_result_t want;
    } frame_row_t;

    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    rcfd_in_if  byte_in();
    rcfd_out_if frame_out();
    rcfd_cfg_if cfg();

    rc_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .frame_out (frame_out),
        .cfg       (cfg)
    );

    // Decoded frames predicted but not yet seen on the output
    frame_result_t expected_frames[$];

    // Traffic shape, in percent per cycle
    int gap_pct;
    int stall_pct;
    bit hold_request;

    int error_count;
    int items_sent;
    int frames_checked;
    int frames_dropped;
    int backpressure_cycles;
    int settings_applied;

    // Model copy of the registers and the frame state
    logic [10:0] stick_center_r = RST_STICK_CENTER;
    logic [10:0] stick_limit_r  = RST_STICK_LIMIT;
    logic [9:0]  deadband_r     = RST_DEADBAND;
    logic [14:0] mouse_limit_r  = RST_MOUSE_LIMIT;
    frame_t      rx_frame       = '0;
    int          rx_count       = 0;
    int          prev_mx        = 0;
    int          prev_my        = 0;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Center a stick, zero it at or past the limit, deadband it if asked,
    // then saturate into the 11-bit signed output range.
    function automatic logic signed [10:0] center_stick(input logic [10:0] raw,
                                                       input bit dead);
        int v;
        int lim;
        int db;
        v   = int'(raw) - int'(stick_center_r);
        lim = int'(stick_limit_r);
        db  = int'(deadband_r);
        if (v >= lim || v <= -lim)
            v = 0;
        if (dead && v <= db && v >= -db)
            v = 0;
        if (v > 1023)
            v = 1023;
        if (v < -1024)
            v = -1024;
        return v[10:0];
    endfunction

    function automatic int clamp_mouse(input logic [15:0] raw);
        int v;
        int lim;
        v   = int'($signed(raw));
        lim = int'(mouse_limit_r);
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        return v;
    endfunction

    // Advance the model by one accepted item; return 1 with the decoded
    // frame when an idle closes a frame of the right length.
    function automatic bit decode_serial_item(input bit idle, input logic [7:0] d,
                                              output frame_result_t res);
        logic [127:0] flat;
        int mx;
        int my;
        res = '0;
        if (!idle)
        begin
            if (rx_count < STORE_DEPTH)
                rx_frame[rx_count] = d;
            if (rx_count < int'(COUNT_MAX))
                rx_count++;
            return 1'b0;
        end
        if (rx_count != FRAME_BYTES)
        begin
            rx_count = 0;
            frames_dropped++;
            return 1'b0;
        end
        rx_count = 0;
        flat = rx_frame;
        mx = clamp_mouse(flat[63:48]);
        my = clamp_mouse(flat[79:64]);
        res.right_x           = center_stick(flat[10:0], 1'b1);
        res.right_y           = center_stick(flat[21:11], 1'b1);
        res.left_x            = center_stick(flat[32:22], 1'b0);
        res.left_y            = center_stick(flat[43:33], 1'b0);
        res.switch_right      = flat[45:44];
        res.switch_left       = flat[47:46];
        res.mouse_x_twice_avg = 17'(mx + prev_mx);
        res.mouse_y_twice_avg = 17'(my + prev_my);
        res.mouse_z           = flat[95:80];
        res.mouse_buttons     = flat[111:96];
        res.key_bits          = flat[127:112];
        prev_mx = mx;
        prev_my = my;
        return 1'b1;
    endfunction

    function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [14:0] d);
        case (idx)
            CFG_STICK_CENTER: stick_center_r = d[10:0];
            CFG_STICK_LIMIT:  stick_limit_r  = d[10:0];
            CFG_DEADBAND:     deadband_r     = d[9:0];
            CFG_MOUSE_LIMIT:  mouse_limit_r  = d[14:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------

    // Pack fields into the 16 stored bytes; byte 0 is the low byte.
    function automatic frame_t pack_frame(
        input logic [10:0] rx, input logic [10:0] ry,
        input logic [10:0] lx, input logic [10:0] ly,
        input logic [1:0] swl, input logic [1:0] swr,
        input logic [15:0] mx, input logic [15:0] my, input logic [15:0] mz,
        input logic [15:0] btn, input logic [15:0] keys
    );
        return {keys, btn, mz, my, mx, swl, swr, ly, lx, ry, rx};
    endfunction

    // Aim raw sticks at the limit and deadband edges of the current
    // settings, and at the rails, more often than at plain random values.
    function automatic logic [10:0] pick_stick_raw();
        int near;
        near = int'($urandom_range(2)) - 1;
        case ($urandom_range(7))
            0: return 11'(stick_center_r + stick_limit_r + near);
            1: return 11'(stick_center_r - stick_limit_r + near);
            2: return 11'(stick_center_r + deadband_r + near);
            3: return 11'(stick_center_r - deadband_r + near);
            4: return $urandom_range(1) ? 11'h7FF : 11'h000;
            default: return 11'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_mouse_raw();
        int near;
        near = int'($urandom_range(2)) - 1;
        case ($urandom_range(5))
            0: return 16'(mouse_limit_r + near);
            1: return 16'(-mouse_limit_r + near);
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame();
        return pack_frame(pick_stick_raw(), pick_stick_raw(), pick_stick_raw(),
                          pick_stick_raw(), 2'($urandom), 2'($urandom),
                          pick_mouse_raw(), pick_mouse_raw(), 16'($urandom),
                          16'($urandom), 16'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    task automatic compare_frame(input frame_result_t got, input frame_result_t want);
        if (got.right_x !== want.right_x)
            flag_error($sformatf("right_x got %0d want %0d", got.right_x, want.right_x));
        if (got.right_y !== want.right_y)
            flag_error($sformatf("right_y got %0d want %0d", got.right_y, want.right_y));
        if (got.left_x !== want.left_x)
            flag_error($sformatf("left_x got %0d want %0d", got.left_x, want.left_x));
        if (got.left_y !== want.left_y)
            flag_error($sformatf("left_y got %0d want %0d", got.left_y, want.left_y));
        if (got.switch_left !== want.switch_left)
            flag_error($sformatf("switch_left got %0d want %0d",
                                 got.switch_left, want.switch_left));
        if (got.switch_right !== want.switch_right)
            flag_error($sformatf("switch_right got %0d want %0d",
                                 got.switch_right, want.switch_right));
        if (got.mouse_x_twice_avg !== want.mouse_x_twice_avg)
            flag_error($sformatf("mouse_x_twice_avg got %0d want %0d",
                                 got.mouse_x_twice_avg, want.mouse_x_twice_avg));
        if (got.mouse_y_twice_avg !== want.mouse_y_twice_avg)
            flag_error($sformatf("mouse_y_twice_avg got %0d want %0d",
                                 got.mouse_y_twice_avg, want.mouse_y_twice_avg));
        if (got.mouse_z !== want.mouse_z)
            flag_error($sformatf("mouse_z got %0d want %0d", got.mouse_z, want.mouse_z));
        if (got.mouse_buttons !== want.mouse_buttons)
            flag_error($sformatf("mouse_buttons got %h want %h",
                                 got.mouse_buttons, want.mouse_buttons));
        if (got.key_bits !== want.key_bits)
            flag_error($sformatf("key_bits got %h want %h", got.key_bits, want.key_bits));
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted. Valid stays high into the
    // next item unless a gap is drawn, so it never toggles within one step.
    task automatic offer_serial_item(input bit idle, input logic [7:0] d,
                                     input bit has_want, input frame_result_t want);
        frame_result_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            byte_in.valid <= 1'b0;
            @(posedge clk);
        end
        byte_in.valid     <= 1'b1;
        byte_in.is_idle   <= idle;
        byte_in.data_byte <= d;
        @(posedge clk);
        while (!byte_in.ready)
        begin
            backpressure_cycles++;
            @(posedge clk);
        end
        items_sent++;
        if (decode_serial_item(idle, d, res))
            expected_frames.push_back(has_want ? want : res);
    endtask

    // Send nbytes data bytes, then the idle that closes the frame.
    task automatic send_frame(input frame_t content, input int nbytes,
                              input bit has_want, input frame_result_t want);
        for (int i = 0; i < nbytes; i++)
            offer_serial_item(1'b0, (i < STORE_DEPTH) ? content[i] : 8'($urandom),
                              1'b0, '0);
        offer_serial_item(1'b1, 8'($urandom), has_want, want);
    endtask

    // Drop valid, wait for every predicted frame, then let the pipeline
    // settle, since a data byte may still be in flight with no result.
    task automatic drain_frames();
        byte_in.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all four registers back to back, keeping valid high throughout.
    task automatic write_settings(input logic [14:0] center, input logic [14:0] limit,
                                  input logic [14:0] dband, input logic [14:0] mlimit);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [14:0]          val[4];
        idx = '{CFG_STICK_CENTER, CFG_STICK_LIMIT, CFG_DEADBAND, CFG_MOUSE_LIMIT};
        val = '{center, limit, dband, mlimit};
        for (int k = 0; k < 4; k++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[k];
            cfg.data  <= val[k];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            store_setting(idx[k], val[k]);
        end
        cfg.valid <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Output side: check each accepted frame, then draw the next ready.
    // A hold request drops ready for a long run of cycles, so that two good
    // frames pile up inside the block and the input gets stalled.
    // ------------------------------------------------------------------
    initial
    begin : frame_sink
        int            hold_left;
        frame_result_t got;
        hold_left       = 0;
        frame_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && frame_out.valid === 1'b1 && frame_out.ready === 1'b1)
            begin
                got.right_x           = frame_out.right_x;
                got.right_y           = frame_out.right_y;
                got.left_x            = frame_out.left_x;
                got.left_y            = frame_out.left_y;
                got.switch_left       = frame_out.switch_left;
                got.switch_right      = frame_out.switch_right;
                got.mouse_x_twice_avg = frame_out.mouse_x_twice_avg;
                got.mouse_y_twice_avg = frame_out.mouse_y_twice_avg;
                got.mouse_z           = frame_out.mouse_z;
                got.mouse_buttons     = frame_out.mouse_buttons;
                got.key_bits          = frame_out.key_bits;
                if (expected_frames.size() == 0)
                    flag_error("decoded frame arrived with none predicted");
                else
                    compare_frame(got, expected_frames.pop_front());
                frames_checked++;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_out.ready <= 1'b0;
            end
            else
            begin
                frame_out.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        frame_row_t    directed_rows[9];
        frame_result_t all_ones;
        int            nbytes;

        // Hold every input at a known value through reset
        rst_n             = 1'b0;
        byte_in.valid     = 1'b0;
        byte_in.is_idle   = 1'b0;
        byte_in.data_byte = 8'h00;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_STICK_CENTER;
        cfg.data          = '0;
        gap_pct           = 18;
        stall_pct         = 18;
        hold_request      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // All-ones frame under reset settings: sticks sit past the limit,
        // both switches read 3, mouse -1 plus the zero history.
        all_ones                   = '0;
        all_ones.switch_left       = 2'd3;
        all_ones.switch_right      = 2'd3;
        all_ones.mouse_x_twice_avg = -17'sd1;
        all_ones.mouse_y_twice_avg = -17'sd1;
        all_ones.mouse_z           = -16'sd1;
        all_ones.mouse_buttons     = 16'hFFFF;
        all_ones.key_bits          = 16'hFFFF;

        // Lone idle: closes an empty frame, nothing comes out
        directed_rows[0] = '{0, '0, 1'b0, '0};
        // All zeros: sticks at -1024 get zeroed, everything reads zero
        directed_rows[1] = '{FRAME_BYTES, '0, 1'b1, '0};
        directed_rows[2] = '{FRAME_BYTES, '1, 1'b1, all_ones};
        // Sticks one inside and exactly at the limit, both signs; mouse
        // at the most negative and most positive values
        directed_rows[3] = '{FRAME_BYTES,
                             pack_frame(11'd1688, 11'd360, 11'd1689, 11'd359, 2'd1, 2'd2,
                                        16'h8000, 16'h7FFF, 16'h8000, 16'h00FF, 16'h8001),
                             1'b0, '0};
        // Right stick at and just past the deadband, left stick inside it;
        // mouse right at the clamp and one beyond
        directed_rows[4] = '{FRAME_BYTES,
                             pack_frame(11'd1034, 11'd1035, 11'd1025, 11'd1014, 2'd2, 2'd1,
                                        16'd60, 16'hFFC3, 16'h7FFF, 16'hFF00, 16'h5AA5),
                             1'b0, '0};
        // One short, one long, and one long enough to saturate the count
        // (50 would wrap back to the good length without saturation)
        directed_rows[5] = '{FRAME_BYTES - 1, {16{8'hA5}}, 1'b0, '0};
        directed_rows[6] = '{FRAME_BYTES + 1, {16{8'h5A}}, 1'b0, '0};
        directed_rows[7] = '{50, {16{8'h3C}}, 1'b0, '0};
        // Good frame after the drops: mouse history must have survived
        directed_rows[8] = '{FRAME_BYTES,
                             pack_frame(11'd1024, 11'd0, 11'd2047, 11'd1023, 2'd0, 2'd3,
                                        16'd61, 16'hFFC4, 16'h0000, 16'h0001, 16'h8000),
                             1'b0, '0};

        foreach (directed_rows[r])
            send_frame(directed_rows[r].content, directed_rows[r].nbytes,
                       directed_rows[r].has_want, directed_rows[r].want);

        // Random frames, one register setting and traffic mix per phase
        for (int phase = 0; phase < 5; phase++)
        begin
            drain_frames();
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    write_settings(15'(RST_STICK_CENTER), 15'(RST_STICK_LIMIT),
                                   15'(RST_DEADBAND), 15'(RST_MOUSE_LIMIT));
                end
                1:
                begin
                    // Widest window: only the top rail is zeroed, sticks saturate
                    gap_pct   = 52;
                    stall_pct = 0;
                    write_settings(15'd0, 15'd2047, 15'd0, 15'd32767);
                end
                2:
                begin
                    // Zero limit: every stick reads 0; mouse clamps to 0
                    gap_pct   = 0;
                    stall_pct = 52;
                    write_settings(15'd2047, 15'd0, 15'd1023, 15'd0);
                end
                3:
                begin
                    gap_pct   = 18;
                    stall_pct = 18;
                    write_settings(15'd1024, 15'd1024, 15'd511, 15'd16384);
                end
                default:
                begin
                    // Random settings, upper data bits included; hold the
                    // output off so the input backs up
                    gap_pct   = 0;
                    stall_pct = 0;
                    write_settings(15'($urandom), 15'($urandom), 15'($urandom),
                                   15'($urandom));
                    hold_request = 1'b1;
                end
            endcase
            for (int f = 0; f < 6; f++)
            begin
                nbytes = ($urandom_range(99) < 80) ? FRAME_BYTES : $urandom_range(45);
                send_frame(random_frame(), nbytes, 1'b0, '0);
            end
        end

        drain_frames();
        $display("Covered %0d serial items under %0d register settings: %0d frames checked,",
                 items_sent, settings_applied, frames_checked);
        $display("%0d frames dropped for length, %0d cycles of input back-pressure.",
                 frames_dropped, backpressure_cycles);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
